@@ hdl/pgw_pkg.sv @@
`timescale 1ns / 1ps
package pgw_pkg;

  localparam int unsigned NUM_AXES = 6;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_ACCUM = 3'd1,
    OP_FUSE  = 3'd2,
    OP_NORM  = 3'd3,
    OP_FILL  = 3'd4,
    OP_DRAW  = 3'd5,
    OP_READ  = 3'd6,
    OP_NONE  = 3'd7
  } op_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_SIZE  = 2'd3;

  localparam logic [2:0] CFG_SIZE_X     = 3'd0;
  localparam logic [2:0] CFG_SIZE_Y     = 3'd1;
  localparam logic [2:0] CFG_SIZE_Z     = 3'd2;
  localparam logic [2:0] CFG_SIZE_YAW   = 3'd3;
  localparam logic [2:0] CFG_SIZE_PITCH = 3'd4;
  localparam logic [2:0] CFG_SIZE_ROLL  = 3'd5;

  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_DIM,
    CMD_CLR_SUM,
    CMD_CLR_I,
    CMD_CELL_RD,
    CMD_CELL_MUL,
    CMD_CELL_UPD,
    CMD_SCAN_RD,
    CMD_SUM_ACC,
    CMD_DIV_INIT_CELL,
    CMD_DIV_INIT_FILL,
    CMD_DIV_STEP,
    CMD_WR_Q,
    CMD_MUL_LO,
    CMD_MUL_HI,
    CMD_DRAW_ACC,
    CMD_RESULT
  } cmd_e;

  typedef enum logic [2:0] {
    RES_OK,
    RES_RANGE,
    RES_ZERO,
    RES_SIZE,
    RES_CELL,
    RES_DRAW
  } res_e;

  typedef struct packed {
    cmd_e act;
    res_e res;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic size_bad;
    logic range_bad;
    logic dim_last;
    logic div_last;
    logic cell_last;
    logic sum_zero;
    logic hit;
  } sts_t;

endpackage

@@ hdl/pgw_dp.sv @@
`timescale 1ns / 1ps
module pgw_dp #(
  parameter int unsigned CELLS   = 4096,
  parameter int unsigned DIM_MAX = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [4:0]          cfg_wdata_i,
  input  logic [2:0]          op_i,
  input  logic [5:0][5:0]     cell_i,
  input  logic [31:0]         value_i,
  input  logic [31:0]         uniform_i,
  input  pgw_pkg::cmd_t       cmd_i,
  output pgw_pkg::sts_t       sts_o,
  output logic                res_valid_o,
  output logic [1:0]          status_o,
  output logic [31:0]         weight_o,
  output logic                found_o,
  output logic [5:0][3:0]     pick_o
);

  localparam int unsigned AW = $clog2(CELLS);
  localparam int unsigned SW = 32 + AW;
  localparam int unsigned PW = AW + 1;
  localparam int unsigned DW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;

  logic [31:0]   mem_q [CELLS];
  logic [31:0]   rdata_q;

  logic [4:0]    dim_q [pgw_pkg::NUM_AXES];
  logic          res_valid_q;

  pgw_pkg::op_e  op_q;
  logic [5:0]    idx_q [pgw_pkg::NUM_AXES];
  logic [31:0]   value_q, uniform_q;
  logic [2:0]    k_q;
  logic [PW-1:0] p_q;
  logic [AW-1:0] flat_q, i_q;
  logic [63:0]   prod_q, lo_q;
  logic [31:0]   weight_q;
  logic [SW-1:0] sum_q, t_q, cum_q, rem_q, div_q;
  logic [31:0]   dlo_q, q_q;
  logic [4:0]    bit_q;
  logic [DW-1:0] cnt_q [pgw_pkg::NUM_AXES];
  logic          found_q;

  logic [1:0]    status_q;
  logic [31:0]   weight_out_q;
  logic          found_out_q;
  logic [5:0][3:0] pick_q;

  // per-step terms
  logic [4:0]      dim_k;
  logic [PW+4:0]   p_prod;
  logic [AW+5:0]   flat_next;
  logic            size_bad, range_bad;
  logic [32:0]     acc_sum;
  logic [64:0]     fuse_rnd;
  logic [31:0]     upd_val;
  logic [31:0]     div_src;
  logic [SW-1:0]   div_den;
  logic [63:0]     div_num;
  logic [SW:0]     div_sh;
  logic            div_ge;
  logic [SW-1:0]   hi_prod;
  logic [SW-1:0]   cum_next;
  logic            hit;
  logic [PW-1:0]   i_plus;
  logic [DW-1:0]   cnt_next [pgw_pkg::NUM_AXES];
  logic            carry;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [31:0]     mem_wdata;

  always_comb begin
    dim_k     = dim_q[k_q];
    p_prod    = (PW+5)'(p_q) * (PW+5)'(dim_k);
    flat_next = (AW+6)'(flat_q) * (AW+6)'(dim_k) + (AW+6)'(idx_q[k_q]);
    size_bad  = (p_q > PW'(CELLS));
    range_bad = 1'b0;
    for (int k = 0; k < pgw_pkg::NUM_AXES; k++) begin
      if (dim_q[k] == 5'd0 || 32'(dim_q[k]) > DIM_MAX) size_bad = 1'b1;
      if (idx_q[k] >= {1'b0, dim_q[k]}) range_bad = 1'b1;
    end
  end

  always_comb begin
    acc_sum  = {1'b0, rdata_q} + {1'b0, value_q};
    fuse_rnd = {1'b0, prod_q} + 65'(64'd1 << 30);
    case (op_q)
      pgw_pkg::OP_WRITE: upd_val = value_q;
      pgw_pkg::OP_ACCUM: upd_val = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
      pgw_pkg::OP_FUSE:  upd_val = (|fuse_rnd[64:63]) ? 32'hFFFF_FFFF : fuse_rnd[62:31];
      default:           upd_val = rdata_q;
    endcase
  end

  // bit-serial restoring divider, dividend = src * 2^31 + den / 2
  always_comb begin
    div_src = (cmd_i.act == pgw_pkg::CMD_DIV_INIT_CELL) ? rdata_q : 32'd1;
    div_den = (cmd_i.act == pgw_pkg::CMD_DIV_INIT_CELL) ? sum_q : SW'(p_q);
    div_num = {1'b0, div_src, 31'b0} + 64'(div_den >> 1);
    div_sh  = {rem_q, dlo_q[31]};
    div_ge  = (div_sh >= {1'b0, div_q});
  end

  always_comb begin
    hi_prod  = SW'(sum_q[SW-1:32]) * SW'(uniform_q);
    cum_next = cum_q + SW'(rdata_q);
    hit      = (cum_next >= t_q);
    i_plus   = PW'(i_q) + PW'(1);
    carry    = 1'b1;
    for (int k = 0; k < pgw_pkg::NUM_AXES; k++) begin
      cnt_next[k] = cnt_q[k];
      if (carry) begin
        if (32'(cnt_q[k]) + 32'd1 == 32'(dim_q[k])) begin
          cnt_next[k] = '0;
        end else begin
          cnt_next[k] = cnt_q[k] + DW'(1);
          carry       = 1'b0;
        end
      end
    end
  end

  always_comb begin
    sts_o.op        = op_q;
    sts_o.size_bad  = size_bad;
    sts_o.range_bad = range_bad;
    sts_o.dim_last  = (k_q == 3'd0);
    sts_o.div_last  = (bit_q == 5'd31);
    sts_o.cell_last = (i_plus == p_q);
    sts_o.sum_zero  = (sum_q == '0);
    sts_o.hit       = hit;
  end

  always_comb begin
    mem_re    = (cmd_i.act == pgw_pkg::CMD_CELL_RD) || (cmd_i.act == pgw_pkg::CMD_SCAN_RD);
    mem_raddr = (cmd_i.act == pgw_pkg::CMD_CELL_RD) ? flat_q : i_q;
    mem_we    = ((cmd_i.act == pgw_pkg::CMD_CELL_UPD) && (op_q != pgw_pkg::OP_READ)) ||
                (cmd_i.act == pgw_pkg::CMD_WR_Q);
    mem_waddr = (cmd_i.act == pgw_pkg::CMD_CELL_UPD) ? flat_q : i_q;
    mem_wdata = (cmd_i.act == pgw_pkg::CMD_CELL_UPD) ? upd_val : q_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < pgw_pkg::NUM_AXES; k++) dim_q[k] <= 5'd1;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (cmd_i.act == pgw_pkg::CMD_RESULT);
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          pgw_pkg::CFG_SIZE_X:     dim_q[0] <= cfg_wdata_i;
          pgw_pkg::CFG_SIZE_Y:     dim_q[1] <= cfg_wdata_i;
          pgw_pkg::CFG_SIZE_Z:     dim_q[2] <= cfg_wdata_i;
          pgw_pkg::CFG_SIZE_YAW:   dim_q[3] <= cfg_wdata_i;
          pgw_pkg::CFG_SIZE_PITCH: dim_q[4] <= cfg_wdata_i;
          pgw_pkg::CFG_SIZE_ROLL:  dim_q[5] <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.act)
      pgw_pkg::CMD_LOAD: begin
        op_q      <= pgw_pkg::op_e'(op_i);
        for (int k = 0; k < pgw_pkg::NUM_AXES; k++) idx_q[k] <= cell_i[k];
        value_q   <= value_i;
        uniform_q <= uniform_i;
        k_q       <= 3'(pgw_pkg::NUM_AXES - 1);
        p_q       <= PW'(1);
        flat_q    <= '0;
      end
      pgw_pkg::CMD_DIM: begin
        p_q    <= (p_prod > (PW+5)'(CELLS)) ? PW'(CELLS + 1) : PW'(p_prod);
        flat_q <= AW'(flat_next);
        k_q    <= k_q - 3'd1;
      end
      pgw_pkg::CMD_CLR_SUM: begin
        sum_q <= '0;
        i_q   <= '0;
      end
      pgw_pkg::CMD_CLR_I: begin
        i_q     <= '0;
        cum_q   <= '0;
        found_q <= 1'b0;
        for (int k = 0; k < pgw_pkg::NUM_AXES; k++) cnt_q[k] <= '0;
      end
      pgw_pkg::CMD_CELL_MUL: prod_q <= rdata_q * value_q;
      pgw_pkg::CMD_CELL_UPD: weight_q <= upd_val;
      pgw_pkg::CMD_SUM_ACC: begin
        sum_q <= sum_q + SW'(rdata_q);
        i_q   <= i_q + AW'(1);
      end
      pgw_pkg::CMD_DIV_INIT_CELL, pgw_pkg::CMD_DIV_INIT_FILL: begin
        rem_q <= SW'(div_num[63:32]);
        dlo_q <= div_num[31:0];
        div_q <= div_den;
        bit_q <= 5'd0;
      end
      pgw_pkg::CMD_DIV_STEP: begin
        rem_q <= div_ge ? SW'(div_sh - {1'b0, div_q}) : SW'(div_sh);
        q_q   <= {q_q[30:0], div_ge};
        dlo_q <= {dlo_q[30:0], 1'b0};
        bit_q <= bit_q + 5'd1;
      end
      pgw_pkg::CMD_WR_Q:   i_q <= i_q + AW'(1);
      pgw_pkg::CMD_MUL_LO: lo_q <= sum_q[31:0] * uniform_q;
      pgw_pkg::CMD_MUL_HI: t_q <= hi_prod + SW'(lo_q[63:32]) + SW'(|lo_q[31:0]);
      pgw_pkg::CMD_DRAW_ACC: begin
        cum_q <= cum_next;
        if (hit) begin
          found_q <= 1'b1;
        end else begin
          i_q <= i_q + AW'(1);
          for (int k = 0; k < pgw_pkg::NUM_AXES; k++) cnt_q[k] <= cnt_next[k];
        end
      end
      pgw_pkg::CMD_RESULT: begin
        status_q     <= pgw_pkg::ST_OK;
        weight_out_q <= '0;
        found_out_q  <= 1'b0;
        pick_q       <= '0;
        case (cmd_i.res)
          pgw_pkg::RES_RANGE: status_q <= pgw_pkg::ST_RANGE;
          pgw_pkg::RES_ZERO:  status_q <= pgw_pkg::ST_ZERO;
          pgw_pkg::RES_SIZE:  status_q <= pgw_pkg::ST_SIZE;
          pgw_pkg::RES_CELL:  weight_out_q <= weight_q;
          pgw_pkg::RES_DRAW: begin
            found_out_q <= found_q;
            if (found_q) begin
              for (int k = 0; k < pgw_pkg::NUM_AXES; k++) pick_q[k] <= 4'(cnt_q[k]);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign status_o    = status_q;
  assign weight_o    = weight_out_q;
  assign found_o     = found_out_q;
  assign pick_o      = pick_q;

endmodule

@@ hdl/pgw_ctrl.sv @@
`timescale 1ns / 1ps
module pgw_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic [2:0]    op_i,
  input  pgw_pkg::sts_t sts_i,
  output pgw_pkg::cmd_t cmd_o,
  output logic          busy
);

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_DIM   = 20'h00002,
    S_CHECK = 20'h00004,
    S_CRD   = 20'h00008,
    S_CMUL  = 20'h00010,
    S_CUPD  = 20'h00020,
    S_SRD   = 20'h00040,
    S_SACC  = 20'h00080,
    S_SCHK  = 20'h00100,
    S_NRD   = 20'h00200,
    S_NINIT = 20'h00400,
    S_DIV   = 20'h00800,
    S_NWR   = 20'h01000,
    S_FINIT = 20'h02000,
    S_FWR   = 20'h04000,
    S_MLO   = 20'h08000,
    S_MHI   = 20'h10000,
    S_PRD   = 20'h20000,
    S_PACC  = 20'h40000,
    S_RES   = 20'h80000
  } state_e;

  state_e        state_q, state_d;
  pgw_pkg::res_e res_q, res_d;

  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    cmd_o.act = pgw_pkg::CMD_IDLE;
    cmd_o.res = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.act = pgw_pkg::CMD_LOAD;
          if (op_i == pgw_pkg::OP_NONE) begin
            res_d   = pgw_pkg::RES_OK;
            state_d = S_RES;
          end else begin
            state_d = S_DIM;
          end
        end
      end
      S_DIM: begin
        cmd_o.act = pgw_pkg::CMD_DIM;
        if (sts_i.dim_last) state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.act = pgw_pkg::CMD_CLR_SUM;
        if (sts_i.size_bad) begin
          res_d   = pgw_pkg::RES_SIZE;
          state_d = S_RES;
        end else begin
          case (sts_i.op) inside
            pgw_pkg::OP_WRITE, pgw_pkg::OP_ACCUM, pgw_pkg::OP_FUSE, pgw_pkg::OP_READ: begin
              if (sts_i.range_bad) begin
                res_d   = pgw_pkg::RES_RANGE;
                state_d = S_RES;
              end else begin
                state_d = S_CRD;
              end
            end
            pgw_pkg::OP_NORM, pgw_pkg::OP_DRAW: state_d = S_SRD;
            pgw_pkg::OP_FILL: state_d = S_FINIT;
            default: begin
              res_d   = pgw_pkg::RES_OK;
              state_d = S_RES;
            end
          endcase
        end
      end
      S_CRD: begin
        cmd_o.act = pgw_pkg::CMD_CELL_RD;
        state_d   = (sts_i.op == pgw_pkg::OP_FUSE) ? S_CMUL : S_CUPD;
      end
      S_CMUL: begin
        cmd_o.act = pgw_pkg::CMD_CELL_MUL;
        state_d   = S_CUPD;
      end
      S_CUPD: begin
        cmd_o.act = pgw_pkg::CMD_CELL_UPD;
        res_d     = pgw_pkg::RES_CELL;
        state_d   = S_RES;
      end
      S_SRD: begin
        cmd_o.act = pgw_pkg::CMD_SCAN_RD;
        state_d   = S_SACC;
      end
      S_SACC: begin
        cmd_o.act = pgw_pkg::CMD_SUM_ACC;
        state_d   = sts_i.cell_last ? S_SCHK : S_SRD;
      end
      S_SCHK: begin
        cmd_o.act = pgw_pkg::CMD_CLR_I;
        if (sts_i.sum_zero) begin
          res_d   = pgw_pkg::RES_ZERO;
          state_d = S_RES;
        end else begin
          state_d = (sts_i.op == pgw_pkg::OP_NORM) ? S_NRD : S_MLO;
        end
      end
      S_NRD: begin
        cmd_o.act = pgw_pkg::CMD_SCAN_RD;
        state_d   = S_NINIT;
      end
      S_NINIT: begin
        cmd_o.act = pgw_pkg::CMD_DIV_INIT_CELL;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.act = pgw_pkg::CMD_DIV_STEP;
        if (sts_i.div_last) state_d = (sts_i.op == pgw_pkg::OP_NORM) ? S_NWR : S_FWR;
      end
      S_NWR: begin
        cmd_o.act = pgw_pkg::CMD_WR_Q;
        if (sts_i.cell_last) begin
          res_d   = pgw_pkg::RES_OK;
          state_d = S_RES;
        end else begin
          state_d = S_NRD;
        end
      end
      S_FINIT: begin
        cmd_o.act = pgw_pkg::CMD_DIV_INIT_FILL;
        state_d   = S_DIV;
      end
      S_FWR: begin
        // one quotient serves every cell
        cmd_o.act = pgw_pkg::CMD_WR_Q;
        if (sts_i.cell_last) begin
          res_d   = pgw_pkg::RES_OK;
          state_d = S_RES;
        end
      end
      S_MLO: begin
        cmd_o.act = pgw_pkg::CMD_MUL_LO;
        state_d   = S_MHI;
      end
      S_MHI: begin
        cmd_o.act = pgw_pkg::CMD_MUL_HI;
        state_d   = S_PRD;
      end
      S_PRD: begin
        cmd_o.act = pgw_pkg::CMD_SCAN_RD;
        state_d   = S_PACC;
      end
      S_PACC: begin
        cmd_o.act = pgw_pkg::CMD_DRAW_ACC;
        if (sts_i.hit || sts_i.cell_last) begin
          res_d   = pgw_pkg::RES_DRAW;
          state_d = S_RES;
        end else begin
          state_d = S_PRD;
        end
      end
      S_RES: begin
        cmd_o.act = pgw_pkg::CMD_RESULT;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= pgw_pkg::RES_OK;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

@@ hdl/pose_grid_weight_sampler_core.sv @@
`timescale 1ns / 1ps
// Six-axis grid of Q1.31 cell weights with write, accumulate, fuse multiply,
// normalize, uniform fill, read and inverse-CDF draw.
// Command channel: a word is taken at a rising edge with start high and busy
// low; busy stays high until the result is issued. One result word per
// command, shown for exactly one cycle with result_valid_o; the receiver
// cannot stall it, and the next command may be started in that cycle.
// Sizes are written through cfg_we_i/cfg_index_i/cfg_wdata_i while idle;
// the user is bound to this, as the block itself does not enforce it. A
// command other than none runs a dimension pass over the six axes, then a
// check, then its operation: cell ops read one cell, multiply for fuse
// multiply and update the cell; fill, normalize and draw pass over the
// cells in use. The cell store (one read or write per cycle) sets the scan
// rate, and the bit-serial divider sets the normalize rate.
// Reset clears control and restores all sizes to 1; cell contents are
// undefined until written, and no clearing pass runs.
module pose_grid_weight_sampler_core #(
  parameter int unsigned CELLS   = 4096,
  parameter int unsigned DIM_MAX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op_i,
  input  logic [5:0]  cell_x_i,
  input  logic [5:0]  cell_y_i,
  input  logic [5:0]  cell_z_i,
  input  logic [5:0]  cell_yaw_i,
  input  logic [5:0]  cell_pitch_i,
  input  logic [5:0]  cell_roll_i,
  input  logic [31:0] value_i,
  input  logic [31:0] uniform_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [31:0] weight_o,
  output logic        found_o,
  output logic [3:0]  pick_x_o,
  output logic [3:0]  pick_y_o,
  output logic [3:0]  pick_z_o,
  output logic [3:0]  pick_yaw_o,
  output logic [3:0]  pick_pitch_o,
  output logic [3:0]  pick_roll_o
);

  pgw_pkg::cmd_t   cmd;
  pgw_pkg::sts_t   sts;
  logic [5:0][5:0] cell_idx;
  logic [5:0][3:0] pick;

  assign cell_idx = {cell_roll_i, cell_pitch_i, cell_yaw_i, cell_z_i, cell_y_i, cell_x_i};

  pgw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  pgw_dp #(
    .CELLS   (CELLS),
    .DIM_MAX (DIM_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (op_i),
    .cell_i      (cell_idx),
    .value_i     (value_i),
    .uniform_i   (uniform_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (result_valid_o),
    .status_o    (status_o),
    .weight_o    (weight_o),
    .found_o     (found_o),
    .pick_o      (pick)
  );

  assign pick_x_o     = pick[0];
  assign pick_y_o     = pick[1];
  assign pick_z_o     = pick[2];
  assign pick_yaw_o   = pick[3];
  assign pick_pitch_o = pick[4];
  assign pick_roll_o  = pick[5];

endmodule
